[src/trqs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trqs_pkg
// shared types and constants for the thread ready queue scheduler
// ----------------------------------------------------------------------------
package trqs_pkg;

    localparam int DefThreads = 16;

    typedef enum logic [1:0] {
        OP_SPAWN = 2'd0,
        OP_YIELD = 2'd1,
        OP_SCHED = 2'd2,
        OP_EXIT  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_NOSLOT  = 2'd2,
        ST_HALTED  = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEARCH,
        S_SPAWN_CHK,
        S_YIELD_CHK,
        S_FIND_REQ,
        S_FIND_CHK,
        S_SHIFT_REQ,
        S_SHIFT_WR,
        S_HEAD_REQ,
        S_HEAD_RD,
        S_DONE
    } t_state;

endpackage

[src/thread_ready_queue_scheduler.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thread_ready_queue_scheduler
// round-robin thread scheduler with per-slot valid bits and a ready queue
// ----------------------------------------------------------------------------
// A command is a transfer when start is high and busy is low. Each command
// gives one result, shown for one cycle with o_done; the receiver cannot
// stall it. The ready queue lives in a synchronous memory with a registered
// read port, and the sequencer walks it one entry per access; the valid
// bits are a register vector that reset sets to thread 0 alone. Per command:
// spawn scans the slots one by one for a free one; yield checks the
// target, scans the queue for it and shifts the entries in front of the
// target back one each; a rejected yield or a yield to self ends after the
// check; sched and exit pop the head; any command while halted goes straight
// to done. The result shows with o_done in the cycle after the last busy
// cycle, and in that same cycle the block already takes the next command.
module thread_ready_queue_scheduler
    import trqs_pkg::*;
#(
    parameter int THREADS = DefThreads
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_op,
    input  logic [5:0] i_target_thread,
    output logic       o_done,
    output logic [1:0] o_status,
    output logic [3:0] o_value,
    output logic [3:0] o_current_thread
);

    localparam int IW = (THREADS > 1) ? $clog2(THREADS) : 1;
    localparam int CW = $clog2(THREADS + 1);

    // valid bits: the store is small and reset must set it at once, so
    // it stays in flip-flops; the ready queue is the memory
    logic [THREADS-1:0] r_valid, n_valid;
    logic [IW-1:0]      r_queue [THREADS];

    t_state        r_state, n_state;
    logic [IW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic [IW-1:0] r_run, n_run;
    logic [IW-1:0] r_sstart, n_sstart;
    logic          r_halted, n_halted;
    logic [IW-1:0] r_tgt, n_tgt;
    logic          r_tgt_bad, n_tgt_bad;
    logic [IW-1:0] r_s, n_s;
    logic [CW-1:0] r_k, n_k;
    logic [1:0]    r_status, n_status;
    logic [3:0]    r_value, n_value;
    logic          r_done, n_done;

    // memory port
    logic          rd_en, wr_en;
    logic [IW-1:0] rd_addr, wr_addr, wr_data;
    logic [IW-1:0] r_rdata;

    // head read may race the requeue write into the same entry
    logic          r_fwd;
    logic [IW-1:0] r_fwd_data;
    logic [IW-1:0] fwd_head;

    function automatic logic [IW-1:0] wrap(input logic [CW:0] v);
        logic [CW:0] t;
        t = v;
        if (t >= (CW+1)'(THREADS)) t = t - (CW+1)'(THREADS);
        return t[IW-1:0];
    endfunction

    function automatic logic [IW-1:0] qpos(input logic [IW-1:0] h,
                                           input logic [CW-1:0] k);
        return wrap((CW+1)'(h) + (CW+1)'(k));
    endfunction

    always_ff @(posedge i_clk) begin
        if (wr_en) r_queue[wr_addr] <= wr_data;
        if (rd_en) r_rdata <= r_queue[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= THREADS'(1);
            r_head   <= '0;
            r_count  <= CW'(1);
            r_run    <= '0;
            r_sstart <= wrap((CW+1)'(1));
            r_halted <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_valid  <= n_valid;
            r_head   <= n_head;
            r_count  <= n_count;
            r_run    <= n_run;
            r_sstart <= n_sstart;
            r_halted <= n_halted;
            r_done   <= n_done;
        end
        r_tgt     <= n_tgt;
        r_tgt_bad <= n_tgt_bad;
        r_s       <= n_s;
        r_k       <= n_k;
        r_status  <= n_status;
        r_value   <= n_value;
    end

    // entry 0 of the queue is never read before written except at reset,
    // where it must hold thread 0: head reads use the running id instead
    // next-state logic
    logic          run_ok;
    logic [CW-1:0] cnt_pop;
    always_comb begin
        n_state = r_state;
        run_ok  = r_valid[r_run];
        cnt_pop = r_count - CW'(1);
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (r_halted) n_state = S_DONE;
                    else begin
                        case (t_op'(i_op))
                            OP_SPAWN: n_state = S_SEARCH;
                            OP_YIELD: n_state = S_YIELD_CHK;
                            default:  n_state = S_HEAD_REQ;
                        endcase
                    end
                end
            end
            S_SEARCH:    n_state = S_SPAWN_CHK;
            S_SPAWN_CHK: n_state = (!r_valid[r_s] || r_k == CW'(THREADS - 1))
                                   ? S_DONE : S_SEARCH;
            S_YIELD_CHK: n_state = (r_tgt_bad || !r_valid[r_tgt] || r_tgt == r_run)
                                   ? S_DONE : S_FIND_REQ;
            S_FIND_REQ:  n_state = (r_k >= r_count) ? S_DONE : S_FIND_CHK;
            S_FIND_CHK:  n_state = (r_rdata == r_tgt) ? S_SHIFT_REQ : S_FIND_REQ;
            S_SHIFT_REQ: n_state = (r_k == '0) ? S_DONE : S_SHIFT_WR;
            S_SHIFT_WR:  n_state = S_SHIFT_REQ;
            S_HEAD_REQ:  n_state = S_HEAD_RD;
            S_HEAD_RD:   n_state = S_DONE;
            S_DONE:      n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_valid   = r_valid;
        n_head    = r_head;
        n_count   = r_count;
        n_run     = r_run;
        n_sstart  = r_sstart;
        n_halted  = r_halted;
        n_tgt     = r_tgt;
        n_tgt_bad = r_tgt_bad;
        n_s       = r_s;
        n_k       = r_k;
        n_status  = r_status;
        n_value   = r_value;
        n_done    = 1'b0;
        rd_en     = 1'b0;
        wr_en     = 1'b0;
        rd_addr   = '0;
        wr_addr   = '0;
        wr_data   = '0;
        case (r_state)
            S_IDLE: begin
                n_tgt     = i_target_thread[IW-1:0];
                // ids at or above the thread count are out of range
                n_tgt_bad = ({1'b0, i_target_thread} >= 7'(THREADS));
                n_s       = r_sstart;
                n_k       = '0;
                n_value   = '0;
                n_status  = ST_OK;
                if (start) begin
                    if (r_halted) n_status = ST_HALTED;
                    else if (t_op'(i_op) == OP_EXIT) n_valid[r_run] = 1'b0;
                end
            end
            S_SPAWN_CHK: begin
                if (!r_valid[r_s]) begin
                    n_valid[r_s] = 1'b1;
                    n_sstart     = wrap((CW+1)'(r_s) + (CW+1)'(1));
                    n_value      = 4'(r_s);
                    if (r_count < CW'(THREADS)) begin
                        wr_en   = 1'b1;
                        wr_addr = qpos(r_head, r_count);
                        wr_data = r_s;
                        n_count = r_count + CW'(1);
                    end
                end else if (r_k == CW'(THREADS - 1)) begin
                    n_status = ST_NOSLOT;
                end else begin
                    n_s = wrap((CW+1)'(r_s) + (CW+1)'(1));
                    n_k = r_k + CW'(1);
                end
            end
            S_YIELD_CHK: begin
                if (r_tgt_bad || !r_valid[r_tgt]) begin
                    n_status = ST_INVALID;
                end else if (r_tgt == r_run) begin
                    n_value = 4'(r_run);
                end else begin
                    n_value = 4'(r_run);
                    // pop then push running at the tail; an empty queue only takes the push
                    if (r_count != '0) begin
                        n_head = wrap((CW+1)'(r_head) + (CW+1)'(1));
                        wr_en   = 1'b1;
                        wr_addr = qpos(n_head, cnt_pop);
                        wr_data = r_run;
                    end else begin
                        wr_en   = 1'b1;
                        wr_addr = r_head;
                        wr_data = r_run;
                        n_count = CW'(1);
                    end
                    n_run = r_tgt;
                    n_k   = '0;
                end
            end
            S_FIND_REQ: begin
                rd_en   = 1'b1;
                rd_addr = qpos(r_head, r_k);
            end
            S_FIND_CHK: begin
                if (r_rdata != r_tgt) n_k = r_k + CW'(1);
            end
            S_SHIFT_REQ: begin
                if (r_k == '0) begin
                    // every entry in front has moved back one: target to head
                    wr_en   = 1'b1;
                    wr_addr = r_head;
                    wr_data = r_tgt;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = qpos(r_head, r_k - CW'(1));
                end
            end
            S_SHIFT_WR: begin
                wr_en   = 1'b1;
                wr_addr = qpos(r_head, r_k);
                wr_data = r_rdata;
                n_k     = r_k - CW'(1);
            end
            S_HEAD_REQ: begin
                if (r_count == '0) begin
                    n_halted = 1'b1;
                    n_status = ST_HALTED;
                end else begin
                    n_head  = wrap((CW+1)'(r_head) + (CW+1)'(1));
                    n_count = cnt_pop;
                    if (run_ok && cnt_pop < CW'(THREADS)) begin
                        wr_en   = 1'b1;
                        wr_addr = qpos(n_head, cnt_pop);
                        wr_data = r_run;
                        n_count = r_count;
                    end
                    if (n_count == '0) begin
                        n_halted = 1'b1;
                        n_status = ST_HALTED;
                    end
                    rd_en   = 1'b1;
                    rd_addr = n_head;
                end
            end
            S_HEAD_RD: begin
                if (!r_halted) n_run = fwd_head;
            end
            S_DONE: n_done = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_fwd      <= wr_en && rd_en && (wr_addr == rd_addr);
        r_fwd_data <= wr_data;
    end
    assign fwd_head = r_fwd ? r_fwd_data : r_rdata;

    assign busy             = (r_state != S_IDLE);
    assign o_done           = r_done;
    assign o_status         = r_status;
    assign o_value          = r_value;
    assign o_current_thread = 4'(r_run);

`ifndef NO_ASSERTIONS
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done held two cycles");
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted) else $error("halted cleared");
    a_halt_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(r_halted, 2)) |-> o_status == ST_HALTED)
        else $error("halted without status");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(THREADS)) else $error("count overflow");
`endif

endmodule
